/* hw/rtl/lz78pe_pkg.sv */
package lz78pe_pkg;

  localparam int BYTE_W     = 8;
  localparam int OUT_CODE_W = 12;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 24;

endpackage

/* hw/rtl/lz78_phrase_encoder_unit.sv */
// Each byte passes IDLE, LOOK and CHECK: the child table is read as it is accepted,
// the entry table is read in LOOK to verify the candidate, and in CHECK any result is
// loaded into the output register once that is free. A new byte is taken only in IDLE.
// A final byte that misses gives two results; FLUSH loads the second as the first is taken.
// Reset clears the phrase count, the pending code and the output valid flag; the
// memories are not cleared and no clearing pass is needed, so input is taken at once.
module lz78_phrase_encoder_unit #(
  parameter int MAX_ENTRIES = 4095
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [lz78pe_pkg::S_TDATA_W-1:0]   s_tdata,  // data_byte[7:0]
  input  logic                               s_tlast,  // is_final
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lz78pe_pkg::M_TDATA_W-1:0]   m_tdata,  // phrase_code[11:0], next_byte[19:12], zero
  output logic                               m_tlast   // end_of_stream
);

  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int BW    = lz78pe_pkg::BYTE_W;
  localparam int OCW   = lz78pe_pkg::OUT_CODE_W;
  localparam int KEY_W = CW + BW;

  typedef enum logic [1:0] {
    IDLE,
    LOOK,
    CHECK,
    FLUSH
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   pending;
  logic [CW-1:0]   cand;
  logic [BW-1:0]   cur_byte;
  logic            cur_fin;
  logic [CW-1:0]   out_code;
  logic [BW-1:0]   out_byte;

  logic            child_re;
  logic [KEY_W-1:0] child_raddr;
  logic [CW-1:0]   child_rdata;
  logic            child_we;
  logic [KEY_W-1:0] cur_key;
  logic            ent_re;
  logic [CW-1:0]   cand_m1;
  logic [AW-1:0]   ent_raddr;
  logic [KEY_W-1:0] ent_rdata;
  logic            ent_we;
  logic            hit;
  logic            out_free;
  logic            go;
  logic            room;
  logic [CW-1:0]   count_inc;
  logic [CW+OCW-1:0] code_ext;
  logic            eos_load;
  logic            out_load;

  assign s_tready    = (state == IDLE);
  assign child_re    = s_tvalid && s_tready;
  assign child_raddr = {pending, s_tdata[BW-1:0]};
  assign cur_key     = {pending, cur_byte};

  assign ent_re    = (state == LOOK);
  assign cand_m1   = child_rdata - CW'(1);
  assign ent_raddr = cand_m1[AW-1:0];

  assign hit       = (cand != '0) && (cand <= count) && (ent_rdata == cur_key);
  assign out_free  = !m_tvalid || m_tready;
  assign go        = (hit && !cur_fin) || out_free;
  assign room      = (count < CW'(MAX_ENTRIES));
  assign count_inc = count + CW'(1);

  assign ent_we   = (state == CHECK) && go && !hit && room;
  assign child_we = ent_we;

  assign eos_load = ((state == CHECK) && go && hit && cur_fin) ||
                    ((state == FLUSH) && out_free);
  assign out_load = eos_load || ((state == CHECK) && go && !hit);

  lz78pe_ram #(
    .WIDTH (CW),
    .DEPTH (1 << KEY_W)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (cur_key),
    .wdata (count_inc),
    .re    (child_re),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  lz78pe_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (count[AW-1:0]),
    .wdata (cur_key),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign code_ext = {{OCW{1'b0}}, out_code};
  assign m_tdata  = {{(lz78pe_pkg::M_TDATA_W - OCW - BW){1'b0}}, out_byte, code_ext[OCW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      pending  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cur_byte <= s_tdata[BW-1:0];
            cur_fin  <= s_tlast;
            state    <= LOOK;
          end
        end
        LOOK: begin
          cand  <= child_rdata;
          state <= CHECK;
        end
        CHECK: begin
          if (go) begin
            if (hit) begin
              if (cur_fin) begin
                out_code <= cand;
                out_byte <= cur_byte;
                m_tlast  <= 1'b1;
                pending  <= '0;
                count    <= '0;
              end else begin
                pending <= cand;
              end
              state <= IDLE;
            end else begin
              out_code <= pending;
              out_byte <= cur_byte;
              m_tlast  <= 1'b0;
              pending  <= '0;
              if (cur_fin) begin
                count <= '0;
                state <= FLUSH;
              end else begin
                if (room) begin
                  count <= count_inc;
                end
                state <= IDLE;
              end
            end
          end
        end
        FLUSH: begin
          if (out_free) begin
            out_code <= '0;
            out_byte <= cur_byte;
            m_tlast  <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("phrase count exceeds the dictionary size");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> (count < CW'(MAX_ENTRIES)) && (state == CHECK))
    else $error("entry written into a full dictionary");

  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 (state == CHECK))
    else $error("accepted byte did not reach the check step");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    eos_load |=> (count == '0) && (pending == '0))
    else $error("dictionary not cleared when the end-of-stream transaction is loaded");

  a_flush_code: assert property (@(posedge clk) disable iff (rst)
    (state == FLUSH) |-> (pending == '0) && !cur_fin == 1'b0)
    else $error("flush pending without a final byte");

endmodule

/* hw/rtl/lz78pe_ram.sv */
module lz78pe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  bit [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
